// ===== rtl/pld_pkg.sv =====
// pld_pkg: shared types and codes of the polyline delta decoder
// no dependencies; used by every rtl module of the block
`timescale 1ns / 1ps

package pld_pkg;

    // command codes of an input word
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // status codes of a result word
    localparam logic [1:0] ST_SEGMENT = 2'd0;
    localparam logic [1:0] ST_BAD_ROP = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;

    // valid raster op range
    localparam logic [7:0] ROP_MIN = 8'd1;
    localparam logic [7:0] ROP_MAX = 8'd16;

    // flag store index width for the largest supported store
    localparam int FLAG_IDX_W = 6;

    typedef struct packed {
        logic               command;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic [7:0]         line_count;
        logic [7:0]         data_size;
        logic [7:0]         rop_code;
        logic [7:0]         pen_colour;
        logic [7:0]         data_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         rop;
        logic signed [15:0] from_x;
        logic signed [15:0] from_y;
        logic signed [15:0] to_x;
        logic signed [15:0] to_y;
        logic [7:0]         colour;
        logic               last;
    } result_t;

    // delta byte phase within one segment
    typedef enum logic [1:0] {
        PH_X_LO = 2'd0,
        PH_X_HI = 2'd1,
        PH_Y_LO = 2'd2,
        PH_Y_HI = 2'd3
    } phase_t;

    // access of the decoder to the flag store
    typedef struct packed {
        logic                  we;
        logic [FLAG_IDX_W-1:0] waddr;
        logic [7:0]            wdata;
        logic [FLAG_IDX_W-1:0] raddr;
    } flag_req_t;

endpackage

// ===== rtl/pld_flag_ram.sv =====
// pld_flag_ram: flag byte store, one write and one registered read per cycle
// depends on pld_pkg (flag_req_t)
`timescale 1ns / 1ps

module pld_flag_ram #(
    parameter int FLAG_STORE_DEPTH = 64
) (
    input  logic                clk,
    input  pld_pkg::flag_req_t  req,
    output logic [7:0]          rdata
);

    localparam int AW = (FLAG_STORE_DEPTH > 1) ? $clog2(FLAG_STORE_DEPTH) : 1;

    logic [7:0] mem [FLAG_STORE_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
    end

    // write-through when the same entry is written and read in one cycle
    always_ff @(posedge clk)
    begin
        if (req.we && (req.waddr == req.raddr))
        begin
            rdata_reg <= req.wdata;
        end
        else
        begin
            rdata_reg <= mem[req.raddr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pld_out_buf.sv =====
// pld_out_buf: two-entry result buffer, output register plus skid stage
// depends on pld_pkg (result_t)
`timescale 1ns / 1ps

module pld_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pld_pkg::result_t  push_word,
    output logic              full,
    output logic              result_valid,
    input  logic              result_stall,
    output pld_pkg::result_t  result
);

    logic             valid0_reg, valid0_next;
    logic             valid1_reg, valid1_next;
    pld_pkg::result_t word0_reg, word0_next;
    pld_pkg::result_t word1_reg, word1_next;
    logic             pop;

    assign pop = valid0_reg && !result_stall;

    always_comb
    begin
        valid0_next = valid0_reg;
        valid1_next = valid1_reg;
        word0_next  = word0_reg;
        word1_next  = word1_reg;
        if (pop)
        begin
            valid0_next = valid1_reg || push;
            word0_next  = valid1_reg ? word1_reg : push_word;
            valid1_next = valid1_reg && push;
            word1_next  = push_word;
        end
        else if (!valid0_reg)
        begin
            valid0_next = push;
            word0_next  = push_word;
        end
        else if (push)
        begin
            valid1_next = 1'b1;
            word1_next  = push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
            valid1_reg <= 1'b0;
        end
        else
        begin
            valid0_reg <= valid0_next;
            valid1_reg <= valid1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word0_reg <= word0_next;
        word1_reg <= word1_next;
    end

    assign full         = valid1_reg;
    assign result_valid = valid0_reg;
    assign result       = word0_reg;

endmodule

// ===== rtl/pld_decode.sv =====
// pld_decode: order state, flag pair lookup and delta accumulation
// depends on pld_pkg; reads and writes the flag store through flag_req_t
`timescale 1ns / 1ps

module pld_decode #(
    parameter int FLAG_STORE_DEPTH = 64,
    parameter int COORD_WIDTH      = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  pld_pkg::item_t     item,
    output pld_pkg::flag_req_t flag_req,
    input  logic [7:0]         flag_rdata,
    output logic               push,
    output pld_pkg::result_t   push_word
);

    localparam int CW = COORD_WIDTH;

    logic [CW-1:0]   cur_x_reg, cur_x_next;
    logic [CW-1:0]   cur_y_reg, cur_y_next;
    logic [CW-1:0]   from_x_reg, from_x_next;
    logic [CW-1:0]   from_y_reg, from_y_next;
    logic [7:0]      pos_reg, pos_next;
    logic [7:0]      seg_idx_reg, seg_idx_next;
    logic [7:0]      lines_reg, lines_next;
    logic [7:0]      size_reg, size_next;
    logic [3:0]      rop_reg, rop_next;
    logic [7:0]      colour_reg, colour_next;
    logic [7:0]      held_reg, held_next;
    logic            active_reg, active_next;
    pld_pkg::phase_t phase_reg, phase_next;

    logic            is_start, bad_rop, data_go, ended, flag_byte, seg_live;
    logic [7:0]      lines_m1, nflag;
    logic            beyond;
    logic [7:0]      fbyte;
    logic [1:0]      raw_pair, pair;
    pld_pkg::phase_t eff_phase;
    logic            long_byte, x_done, y_done, seg_done, last_seg;
    logic signed [14:0] d_long;
    logic signed [6:0]  d_short;
    logic [CW-1:0]   delta, new_x, new_y, seg_from_x, seg_from_y;

    // ---------------------------------------------------------------
    // decode of the current word
    // ---------------------------------------------------------------
    assign is_start = accept && (item.command == pld_pkg::CMD_START);
    assign bad_rop  = (item.rop_code < pld_pkg::ROP_MIN) || (item.rop_code > pld_pkg::ROP_MAX);
    assign data_go  = accept && (item.command == pld_pkg::CMD_DATA) && active_reg;

    assign ended    = ({1'b0, pos_reg} + 9'd1) >= {1'b0, size_reg};
    assign lines_m1 = lines_reg - 8'd1;
    assign nflag    = (lines_reg == 8'd0) ? 8'd1 : ({2'b00, lines_m1[7:2]} + 8'd1);
    assign flag_byte = pos_reg < nflag;
    assign seg_live  = !flag_byte && (seg_idx_reg < lines_reg);

    // flag byte of the current segment sits in the ram output register
    assign beyond = {1'b0, seg_idx_reg[7:2]} >= 7'(FLAG_STORE_DEPTH);
    assign fbyte  = beyond ? 8'h00 : flag_rdata;

    always_comb
    begin
        unique case (seg_idx_reg[1:0])
            2'd0:    raw_pair = fbyte[7:6];
            2'd1:    raw_pair = fbyte[5:4];
            2'd2:    raw_pair = fbyte[3:2];
            default: raw_pair = fbyte[1:0];
        endcase
    end

    // a zero pair means both coordinates change
    assign pair = (raw_pair == 2'b00) ? 2'b11 : raw_pair;

    assign eff_phase = ((phase_reg == pld_pkg::PH_X_LO) && !pair[0]) ? pld_pkg::PH_Y_LO
                                                                      : phase_reg;
    assign long_byte = item.data_byte[7];
    assign x_done = ((eff_phase == pld_pkg::PH_X_LO) && !long_byte)
                 || (eff_phase == pld_pkg::PH_X_HI);
    assign y_done = ((eff_phase == pld_pkg::PH_Y_LO) && !long_byte)
                 || (eff_phase == pld_pkg::PH_Y_HI);
    assign seg_done = seg_live && (y_done || (x_done && !pair[1]));
    assign last_seg = (({1'b0, seg_idx_reg} + 9'd1) >= {1'b0, lines_reg}) || ended;

    assign d_long  = signed'({held_reg[6:0], item.data_byte});
    assign d_short = signed'(item.data_byte[6:0]);
    assign delta   = ((eff_phase == pld_pkg::PH_X_HI) || (eff_phase == pld_pkg::PH_Y_HI))
                   ? CW'(d_long) : CW'(d_short);

    assign new_x = (seg_live && x_done) ? (cur_x_reg + delta) : cur_x_reg;
    assign new_y = (seg_live && y_done) ? (cur_y_reg + delta) : cur_y_reg;
    assign seg_from_x = (phase_reg == pld_pkg::PH_X_LO) ? cur_x_reg : from_x_reg;
    assign seg_from_y = (phase_reg == pld_pkg::PH_X_LO) ? cur_y_reg : from_y_reg;

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    always_comb
    begin
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        from_x_next  = from_x_reg;
        from_y_next  = from_y_reg;
        pos_next     = pos_reg;
        seg_idx_next = seg_idx_reg;
        lines_next   = lines_reg;
        size_next    = size_reg;
        rop_next     = rop_reg;
        colour_next  = colour_reg;
        held_next    = held_reg;
        active_next  = active_reg;
        phase_next   = phase_reg;
        if (is_start)
        begin
            if (bad_rop)
            begin
                active_next = 1'b0;
            end
            else
            begin
                lines_next   = item.line_count;
                size_next    = item.data_size;
                rop_next     = 4'(item.rop_code - 8'd1);
                colour_next  = item.pen_colour;
                cur_x_next   = CW'(item.start_x);
                cur_y_next   = CW'(item.start_y);
                from_x_next  = CW'(item.start_x);
                from_y_next  = CW'(item.start_y);
                pos_next     = 8'd0;
                seg_idx_next = 8'd0;
                held_next    = 8'd0;
                phase_next   = pld_pkg::PH_X_LO;
                active_next  = (item.data_size != 8'd0);
            end
        end
        else if (data_go)
        begin
            pos_next = pos_reg + 8'd1;
            if (ended)
            begin
                active_next = 1'b0;
            end
            if (seg_live)
            begin
                cur_x_next  = new_x;
                cur_y_next  = new_y;
                from_x_next = seg_from_x;
                from_y_next = seg_from_y;
                if (seg_done)
                begin
                    phase_next   = pld_pkg::PH_X_LO;
                    seg_idx_next = seg_idx_reg + 8'd1;
                    if (last_seg)
                    begin
                        active_next = 1'b0;
                    end
                end
                else if (ended)
                begin
                    phase_next = pld_pkg::PH_X_LO;
                end
                else if (x_done)
                begin
                    phase_next = pld_pkg::PH_Y_LO;
                end
                else if (eff_phase == pld_pkg::PH_X_LO)
                begin
                    phase_next = pld_pkg::PH_X_HI;
                    held_next  = item.data_byte;
                end
                else
                begin
                    phase_next = pld_pkg::PH_Y_HI;
                    held_next  = item.data_byte;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // outputs: flag store access and result word
    // ---------------------------------------------------------------
    always_comb
    begin
        flag_req.we    = data_go && flag_byte
                      && ({1'b0, pos_reg} < 9'(FLAG_STORE_DEPTH));
        flag_req.waddr = pos_reg[pld_pkg::FLAG_IDX_W-1:0];
        flag_req.wdata = item.data_byte;
        // fetch the flag byte of the segment that the next word works on
        flag_req.raddr = seg_idx_next[7:2];
    end

    always_comb
    begin
        push      = 1'b0;
        push_word = '0;
        if (is_start && bad_rop)
        begin
            push             = 1'b1;
            push_word.status = pld_pkg::ST_BAD_ROP;
            push_word.last   = 1'b1;
        end
        else if (data_go && seg_live && (seg_done || ended))
        begin
            push             = 1'b1;
            push_word.status = seg_done ? pld_pkg::ST_SEGMENT : pld_pkg::ST_TRUNC;
            push_word.rop    = rop_reg;
            push_word.from_x = seg_from_x[15:0];
            push_word.from_y = seg_from_y[15:0];
            push_word.to_x   = new_x[15:0];
            push_word.to_y   = new_y[15:0];
            push_word.colour = colour_reg;
            push_word.last   = seg_done ? last_seg : 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 8'd0;
            seg_idx_reg <= 8'd0;
            active_reg  <= 1'b0;
            phase_reg   <= pld_pkg::PH_X_LO;
        end
        else
        begin
            pos_reg     <= pos_next;
            seg_idx_reg <= seg_idx_next;
            active_reg  <= active_next;
            phase_reg   <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg  <= cur_x_next;
        cur_y_reg  <= cur_y_next;
        from_x_reg <= from_x_next;
        from_y_reg <= from_y_next;
        lines_reg  <= lines_next;
        size_reg   <= size_next;
        rop_reg    <= rop_next;
        colour_reg <= colour_next;
        held_reg   <= held_next;
    end

endmodule

// ===== rtl/polyline_delta_decoder.sv =====
// polyline_delta_decoder: top level, decodes delta-coded polyline orders a byte a word
// depends on pld_pkg, pld_flag_ram, pld_decode, pld_out_buf
//
//   channel   valid          stall          word
//   input     item_valid     item_stall     item   (pld_pkg::item_t)
//   output    result_valid   result_stall   result (pld_pkg::result_t)
//
// one input word is taken every cycle while item_stall is low; results are registered.
// the flag byte of the next segment is fetched ahead from the flag ram,
// with write-through when a flag byte lands on the entry being fetched.
// item_stall rises only when both result slots hold words nobody has taken.
// reset is asynchronous; the flag store needs no clearing, so no wait after reset.
`timescale 1ns / 1ps

module polyline_delta_decoder #(
    parameter int FLAG_STORE_DEPTH = 64,
    parameter int COORD_WIDTH      = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  pld_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_stall,
    output pld_pkg::result_t  result
);

    logic               accept;
    logic               full;
    logic               push;
    pld_pkg::result_t   push_word;
    pld_pkg::flag_req_t flag_req;
    logic [7:0]         flag_rdata;

    assign item_stall = full;
    assign accept     = item_valid && !item_stall;

    pld_flag_ram #(
        .FLAG_STORE_DEPTH(FLAG_STORE_DEPTH)
    ) u_flag_ram (
        .clk   (clk),
        .req   (flag_req),
        .rdata (flag_rdata)
    );

    pld_decode #(
        .FLAG_STORE_DEPTH(FLAG_STORE_DEPTH),
        .COORD_WIDTH     (COORD_WIDTH)
    ) u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item       (item),
        .flag_req   (flag_req),
        .flag_rdata (flag_rdata),
        .push       (push),
        .push_word  (push_word)
    );

    pld_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_word    (push_word),
        .full         (full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // a full buffer always presents a word
    a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("input stalled with no result pending");

    // a bad raster op start is always followed by a valid result word on the next cycle
    a_bad_rop_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.command == pld_pkg::CMD_START)
            && ((item.rop_code < pld_pkg::ROP_MIN) || (item.rop_code > pld_pkg::ROP_MAX)))
        |=> result_valid)
        else $error("bad raster op start gave no result");

    // bad-op and truncated results always close the order
    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status != pld_pkg::ST_SEGMENT)) |-> result.last)
        else $error("error result not marked last");

    // flag store is never written while a data word is not accepted
    a_flag_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        flag_req.we |-> (accept && (item.command == pld_pkg::CMD_DATA)))
        else $error("flag store written without a data word");

endmodule
